FILE: design/rble_pkg.sv
package rble_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_OK    = 2'd2;
	localparam logic [1:0] CMD_ACK   = 2'd3;

	localparam logic [1:0] MT_START = 2'd0;
	localparam logic [1:0] MT_OK    = 2'd1;
	localparam logic [1:0] MT_ACK   = 2'd2;

	localparam logic CFG_PEER_COUNT = 1'b0;
	localparam logic CFG_MY_INDEX   = 1'b1;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_START,
		OP_OK,
		OP_ACK
	} rble_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_TICK,
		S_OKACK,
		S_BEGIN,
		S_EMIT
	} rble_state_t;

	typedef struct packed {
		rble_op_t    op;
		logic [31:0] k;
		logic [2:0]  from;
		logic [7:0]  trust;
	} rble_item_t;

	typedef struct packed {
		logic       valid;
		rble_item_t item;
	} rble_qout_t;

	typedef struct packed {
		logic [3:0] peer_count;
		logic [2:0] my_index;
	} rble_cfg_t;

	typedef struct packed {
		logic [1:0]  mtype;
		logic [31:0] rnd;
		logic        bcast;
		logic [2:0]  dest;
		logic [7:0]  trust;
		logic [31:0] seq;
	} rble_rec_t;

	typedef struct packed {
		logic        has_msg;
		logic [1:0]  msg_type;
		logic [31:0] msg_round;
		logic        broadcast;
		logic [2:0]  dest_peer;
		logic [7:0]  msg_trust;
		logic [31:0] msg_seq;
		logic [31:0] round_now;
		logic [2:0]  leader_now;
		logic        last;
	} rble_res_t;

endpackage

FILE: design/rble_if.sv
interface rble_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] round_k;
	logic [2:0]  from_peer;
	logic [7:0]  trust_mask;
	logic        msg_valid;

	modport source(output valid, cmd, round_k, from_peer, trust_mask, msg_valid, input ready);
	modport sink(input valid, cmd, round_k, from_peer, trust_mask, msg_valid, output ready);
endinterface

interface rble_rsp_if;
	logic        valid;
	logic        ready;
	logic        has_msg;
	logic [1:0]  msg_type;
	logic [31:0] msg_round;
	logic        broadcast;
	logic [2:0]  dest_peer;
	logic [7:0]  msg_trust;
	logic [31:0] msg_seq;
	logic [31:0] round_now;
	logic [2:0]  leader_now;
	logic        last;

	modport source(output valid, has_msg, msg_type, msg_round, broadcast, dest_peer,
		msg_trust, msg_seq, round_now, leader_now, last, input ready);
	modport sink(input valid, has_msg, msg_type, msg_round, broadcast, dest_peer,
		msg_trust, msg_seq, round_now, leader_now, last, output ready);
endinterface

FILE: design/round_based_leader_election.sv
// Round-based leader election node. Each request (timer tick, START, OK or ACK)
// produces up to two outgoing messages followed by one status item with last set.
// A request accepted into the queue is taken by the idle node into a decide state.
// When a round modulo is needed, the node waits for the bit-serial modulo unit, and
// a tick that opens a new round runs two modulos in turn. The results are then
// registered one by one at the output, and each waits while the receiver holds off
// the result before it.
// A two-entry queue accepts new requests while earlier ones are processed.
// Configuration must be written only while the node is idle; the block does not enforce this.
module round_based_leader_election #(
	parameter int MAX_PEERS = 8,
	parameter int ROUND_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	rble_req_if.sink   req,
	rble_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [3:0] cfg_data
);

	rble_pkg::rble_cfg_t  cfg_q;
	rble_pkg::rble_qout_t qout;
	logic                 pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peer_count <= 4'd1;
			cfg_q.my_index <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				rble_pkg::CFG_PEER_COUNT: cfg_q.peer_count <= cfg_data;
				rble_pkg::CFG_MY_INDEX:   cfg_q.my_index <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	rble_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .pop(pop), .qout(qout)
	);

	rble_back #(.MAX_PEERS(MAX_PEERS), .ROUND_BITS(ROUND_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .qin(qout), .pop(pop), .rsp(rsp)
	);

endmodule

FILE: design/rble_front.sv
module rble_front (
	input  logic              clk,
	input  logic              arst_n,
	rble_req_if.sink          req,
	input  logic              pop,
	output rble_pkg::rble_qout_t qout
);

	rble_pkg::rble_item_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	rble_pkg::rble_item_t item;

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;

	always_comb begin
		item.k = req.round_k;
		item.from = req.from_peer;
		item.trust = req.trust_mask;
		case (req.cmd)
			rble_pkg::CMD_TICK:  item.op = rble_pkg::OP_TICK;
			rble_pkg::CMD_START: item.op = req.msg_valid ? rble_pkg::OP_START : rble_pkg::OP_NOP;
			rble_pkg::CMD_OK:    item.op = req.msg_valid ? rble_pkg::OP_OK : rble_pkg::OP_NOP;
			rble_pkg::CMD_ACK:   item.op = req.msg_valid ? rble_pkg::OP_ACK : rble_pkg::OP_NOP;
			default:             item.op = rble_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign qout.valid = (cnt_q != 2'd0);
	assign qout.item = mem_q[rd_q];

endmodule

FILE: design/rble_mod.sv
module rble_mod #(
	parameter int RB = 32,
	parameter int NW = 4,
	parameter int PW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RB-1:0] opnd,
	input  logic [NW-1:0] n,
	output logic          done,
	output logic [PW-1:0] res
);

	localparam int CW = $clog2(RB + 1);

	logic [RB-1:0] sh_q;
	logic [NW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0]   t;
	logic [NW:0]   t_red;

	always_comb begin
		t = {rem_q, sh_q[RB-1]};
		t_red = (t >= {1'b0, n}) ? t - {1'b0, n} : t;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= opnd;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			sh_q <= {sh_q[RB-2:0], 1'b0};
			rem_q <= t_red[NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(RB);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = (cnt_q == '0);
	assign res = PW'(rem_q);

endmodule

FILE: design/rble_back.sv
module rble_back #(
	parameter int MAX_PEERS = 8,
	parameter int ROUND_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rble_pkg::rble_cfg_t  cfg,
	input  rble_pkg::rble_qout_t qin,
	output logic                 pop,
	rble_rsp_if.source           rsp
);

	localparam int RB = ROUND_BITS;
	localparam int NW = $clog2(MAX_PEERS + 1);
	localparam int PW = $clog2(MAX_PEERS);
	localparam int LM = (MAX_PEERS < 8) ? MAX_PEERS : 8;

	rble_pkg::rble_state_t state_q, state_d;
	rble_pkg::rble_op_t    op_q, op_d;
	logic [RB-1:0] k_q, k_d, round_q, round_d, s_q, s_d;
	logic [2:0]    from_q, from_d;
	logic [7:0]    trust_q, trust_d;
	logic [PW-1:0] leader_q, leader_d;
	logic [1:0]    ttl_q [MAX_PEERS];
	logic [1:0]    ttl_d [MAX_PEERS];
	logic [1:0]    aged [MAX_PEERS];
	logic [1:0]    tick_q, tick_d, tick_nx;
	logic [31:0]   seq_q, seq_d, seqv;
	rble_pkg::rble_rec_t rec_q [2];
	rble_pkg::rble_rec_t rec_d [2];
	logic [1:0]    cnt_q, cnt_d, c, idx_q, idx_d;
	logic          ack_first_q, ack_first_d;
	rble_pkg::rble_res_t out_q, out_d;
	logic          out_v_q, out_v_d;
	logic          load;
	logic          mod_start, mod_done;
	logic [RB-1:0] mod_opnd;
	logic [PW-1:0] mod_res;
	logic [NW-1:0] n;
	logic [RB-1:0] next_r;
	logic [7:0]    live;
	logic          my_lead;

	rble_mod #(.RB(RB), .NW(NW), .PW(PW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .opnd(mod_opnd),
		.n(n), .done(mod_done), .res(mod_res)
	);

	always_comb begin
		if (cfg.peer_count == 4'd0) begin
			n = NW'(1);
		end else if (32'(cfg.peer_count) > MAX_PEERS) begin
			n = NW'(MAX_PEERS);
		end else begin
			n = NW'(cfg.peer_count);
		end
		next_r = (&round_q) ? round_q : round_q + 1'b1;
		my_lead = (32'(cfg.my_index) == 32'(mod_res));
		live = 8'd0;
		for (int i = 0; i < MAX_PEERS; i++) begin
			aged[i] = (i < 32'(n) && ttl_q[i] != 2'd0) ? ttl_q[i] - 2'd1 : ttl_q[i];
		end
		for (int i = 0; i < LM; i++) begin
			live[i] = (i < 32'(n)) && (aged[i] != 2'd0);
		end
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		k_d = k_q;
		from_d = from_q;
		trust_d = trust_q;
		round_d = round_q;
		leader_d = leader_q;
		s_d = s_q;
		ttl_d = ttl_q;
		tick_d = tick_q;
		tick_nx = tick_q + 2'd1;
		seq_d = seq_q;
		seqv = seq_q;
		rec_d = rec_q;
		cnt_d = cnt_q;
		c = cnt_q;
		idx_d = idx_q;
		ack_first_d = ack_first_q;
		out_d = out_q;
		out_v_d = rsp.ready ? 1'b0 : out_v_q;
		load = 1'b0;
		pop = 1'b0;
		mod_start = 1'b0;
		mod_opnd = round_q;
		case (state_q)
			rble_pkg::S_IDLE: begin
				if (qin.valid) begin
					pop = 1'b1;
					op_d = qin.item.op;
					k_d = RB'(qin.item.k);
					from_d = qin.item.from;
					trust_d = qin.item.trust;
					cnt_d = 2'd0;
					ack_first_d = 1'b0;
					state_d = rble_pkg::S_DECIDE;
				end
			end
			rble_pkg::S_DECIDE: begin
				case (op_q)
					rble_pkg::OP_TICK: begin
						mod_start = 1'b1;
						state_d = rble_pkg::S_TICK;
					end
					rble_pkg::OP_START: begin
						if (k_q != round_q) begin
							s_d = (k_q > round_q) ? k_q : round_q;
							mod_opnd = s_d;
							mod_start = 1'b1;
							state_d = rble_pkg::S_BEGIN;
						end else begin
							state_d = rble_pkg::S_EMIT;
						end
					end
					rble_pkg::OP_OK: begin
						if (k_q > round_q) begin
							ack_first_d = 1'b1;
							s_d = k_q;
							mod_opnd = k_q;
							mod_start = 1'b1;
							state_d = rble_pkg::S_BEGIN;
						end else if (k_q < round_q) begin
							rec_d[0] = '{rble_pkg::MT_START, 32'(round_q), 1'b0, from_q,
								8'd0, seq_q};
							seq_d = seq_q + 32'd1;
							cnt_d = 2'd1;
							state_d = rble_pkg::S_EMIT;
						end else if (!trust_q[cfg.my_index]) begin
							s_d = next_r;
							mod_opnd = next_r;
							mod_start = 1'b1;
							state_d = rble_pkg::S_BEGIN;
						end else begin
							mod_start = 1'b1;
							state_d = rble_pkg::S_OKACK;
						end
					end
					rble_pkg::OP_ACK: begin
						if (k_q == round_q && 32'(from_q) < 32'(n)) begin
							for (int i = 0; i < MAX_PEERS; i++) begin
								if (32'(i) == 32'(from_q)) begin
									ttl_d[i] = 2'd3;
								end
							end
						end
						state_d = rble_pkg::S_EMIT;
					end
					default: begin
						state_d = rble_pkg::S_EMIT;
					end
				endcase
			end
			rble_pkg::S_TICK: begin
				if (mod_done) begin
					if (my_lead) begin
						ttl_d = aged;
						rec_d[0] = '{rble_pkg::MT_OK, 32'(round_q), 1'b1, 3'd0, live, seq_q};
						seq_d = seq_q + 32'd1;
						cnt_d = 2'd1;
					end
					if (tick_nx == 2'd3) begin
						tick_d = 2'd0;
						s_d = next_r;
						mod_opnd = next_r;
						mod_start = 1'b1;
						state_d = rble_pkg::S_BEGIN;
					end else begin
						tick_d = tick_nx;
						state_d = rble_pkg::S_EMIT;
					end
				end
			end
			rble_pkg::S_OKACK: begin
				if (mod_done) begin
					for (int i = 0; i < LM; i++) begin
						if (i < 32'(n) && trust_q[i]) begin
							ttl_d[i] = 2'd1;
						end
					end
					rec_d[0] = '{rble_pkg::MT_ACK, 32'(round_q), 1'b0, 3'(mod_res), 8'd0, seq_q};
					seq_d = seq_q + 32'd1;
					cnt_d = 2'd1;
					tick_d = 2'd0;
					state_d = rble_pkg::S_EMIT;
				end
			end
			rble_pkg::S_BEGIN: begin
				if (mod_done) begin
					if (ack_first_q) begin
						rec_d[c[0]] = '{rble_pkg::MT_ACK, 32'(s_q), 1'b0, 3'(mod_res), 8'd0, seqv};
						seqv = seqv + 32'd1;
						c = c + 2'd1;
					end
					if (!my_lead) begin
						rec_d[c[0]] = '{rble_pkg::MT_START, 32'(s_q), 1'b1, 3'd0, 8'd0, seqv};
						seqv = seqv + 32'd1;
						c = c + 2'd1;
					end
					seq_d = seqv;
					cnt_d = c;
					round_d = s_q;
					leader_d = mod_res;
					for (int i = 0; i < MAX_PEERS; i++) begin
						if (i < 32'(n)) begin
							ttl_d[i] = 2'd3;
						end
					end
					tick_d = 2'd0;
					state_d = rble_pkg::S_EMIT;
				end
			end
			rble_pkg::S_EMIT: begin
				if (!out_v_q || rsp.ready) begin
					load = 1'b1;
					out_v_d = 1'b1;
					out_d.round_now = 32'(round_q);
					out_d.leader_now = 3'(leader_q);
					if (idx_q < cnt_q) begin
						out_d.has_msg = 1'b1;
						out_d.msg_type = rec_q[idx_q[0]].mtype;
						out_d.msg_round = rec_q[idx_q[0]].rnd;
						out_d.broadcast = rec_q[idx_q[0]].bcast;
						out_d.dest_peer = rec_q[idx_q[0]].dest;
						out_d.msg_trust = rec_q[idx_q[0]].trust;
						out_d.msg_seq = rec_q[idx_q[0]].seq;
						out_d.last = 1'b0;
						idx_d = idx_q + 2'd1;
					end else begin
						out_d.has_msg = 1'b0;
						out_d.msg_type = 2'd0;
						out_d.msg_round = 32'd0;
						out_d.broadcast = 1'b0;
						out_d.dest_peer = 3'd0;
						out_d.msg_trust = 8'd0;
						out_d.msg_seq = 32'd0;
						out_d.last = 1'b1;
						idx_d = 2'd0;
						cnt_d = 2'd0;
						state_d = rble_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = rble_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		k_q <= k_d;
		from_q <= from_d;
		trust_q <= trust_d;
		s_q <= s_d;
		rec_q <= rec_d;
		out_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rble_pkg::S_IDLE;
			round_q <= '0;
			leader_q <= '0;
			for (int i = 0; i < MAX_PEERS; i++) begin
				ttl_q[i] <= 2'd3;
			end
			tick_q <= 2'd0;
			seq_q <= 32'd0;
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
			ack_first_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
			leader_q <= leader_d;
			ttl_q <= ttl_d;
			tick_q <= tick_d;
			seq_q <= seq_d;
			cnt_q <= cnt_d;
			idx_q <= idx_d;
			ack_first_q <= ack_first_d;
			out_v_q <= out_v_d;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.has_msg = out_q.has_msg;
	assign rsp.msg_type = out_q.msg_type;
	assign rsp.msg_round = out_q.msg_round;
	assign rsp.broadcast = out_q.broadcast;
	assign rsp.dest_peer = out_q.dest_peer;
	assign rsp.msg_trust = out_q.msg_trust;
	assign rsp.msg_seq = out_q.msg_seq;
	assign rsp.round_now = out_q.round_now;
	assign rsp.leader_now = out_q.leader_now;
	assign rsp.last = out_q.last;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rble_pkg::S_IDLE) |-> (cnt_q == 2'd0 && idx_q == 2'd0))
		else $error("record list not empty in idle");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd3) && (idx_q <= cnt_q))
		else $error("record count out of range");
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q != 2'd3)
		else $error("tick count reached three");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && out_d.last) |=> (state_q == rble_pkg::S_IDLE))
		else $error("status item not followed by idle");

endmodule

FILE: sim/round_based_leader_election_tb.sv
module round_based_leader_election_tb;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [3:0] cfg_data;

	rble_req_if req();
	rble_rsp_if rsp();

	round_based_leader_election u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	logic [31:0] node_round;
	logic [2:0] node_leader;
	logic [1:0] lifetime [8];
	logic [1:0] ticks;
	logic [31:0] next_seq;
	logic [3:0] group_size;
	logic [2:0] self_index;

	rble_pkg::rble_res_t expected_msgs[$];
	rble_pkg::rble_res_t step_buf[$];
	int errors;
	bit src_idle_on;
	bit snk_idle_on;
	int hold_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [3:0] active_peers();
		if (group_size == 4'd0) return 4'd1;
		if (group_size > 4'd8) return 4'd8;
		return group_size;
	endfunction

	function automatic logic [2:0] round_mod(logic [31:0] r);
		return 3'(r % active_peers());
	endfunction

	function automatic logic [31:0] following_round();
		return (node_round == 32'hFFFF_FFFF) ? node_round : node_round + 32'd1;
	endfunction

	function automatic logic [7:0] alive_mask();
		logic [7:0] m;
		m = '0;
		for (int i = 0; i < active_peers(); i++)
			if (lifetime[i] != 2'd0) m[i] = 1'b1;
		return m;
	endfunction

	task automatic push_msg(logic [1:0] t, logic [31:0] r, logic b, logic [2:0] d,
		logic [7:0] tr);
		rble_pkg::rble_res_t e;
		e = '0;
		e.has_msg = 1'b1;
		e.msg_type = t;
		e.msg_round = r;
		e.broadcast = b;
		e.dest_peer = d;
		e.msg_trust = tr;
		e.msg_seq = next_seq;
		next_seq = next_seq + 32'd1;
		step_buf.push_back(e);
	endtask

	task automatic open_round(logic [31:0] s);
		if ({1'b0, self_index} != {1'b0, round_mod(s)})
			push_msg(rble_pkg::MT_START, s, 1'b1, 3'd0, 8'd0);
		node_round = s;
		node_leader = round_mod(s);
		for (int i = 0; i < active_peers(); i++) lifetime[i] = 2'd3;
		ticks = 2'd0;
	endtask

	task automatic predict_request(logic [1:0] c, logic [31:0] k, logic [2:0] from,
		logic [7:0] tr, logic v);
		rble_pkg::rble_res_t st;
		step_buf = {};
		if (c == rble_pkg::CMD_TICK) begin
			if (self_index == round_mod(node_round)) begin
				for (int i = 0; i < active_peers(); i++)
					if (lifetime[i] != 2'd0) lifetime[i] = lifetime[i] - 2'd1;
				push_msg(rble_pkg::MT_OK, node_round, 1'b1, 3'd0, alive_mask());
			end
			ticks = ticks + 2'd1;
			if (ticks > 2'd2) open_round(following_round());
		end else if (v && c == rble_pkg::CMD_START) begin
			if (k > node_round) open_round(k);
			else if (k < node_round) open_round(node_round);
		end else if (v && c == rble_pkg::CMD_OK) begin
			if (k > node_round) begin
				push_msg(rble_pkg::MT_ACK, k, 1'b0, round_mod(k), 8'd0);
				open_round(k);
			end else if (k < node_round) begin
				push_msg(rble_pkg::MT_START, node_round, 1'b0, from, 8'd0);
			end else if (!tr[self_index]) begin
				open_round(following_round());
			end else begin
				for (int i = 0; i < active_peers(); i++)
					if (tr[i]) lifetime[i] = 2'd1;
				push_msg(rble_pkg::MT_ACK, node_round, 1'b0, round_mod(node_round), 8'd0);
				ticks = 2'd0;
			end
		end else if (v && c == rble_pkg::CMD_ACK) begin
			if (k == node_round && {1'b0, from} < active_peers()) lifetime[from] = 2'd3;
		end
		st = '0;
		st.last = 1'b1;
		step_buf.push_back(st);
		foreach (step_buf[j]) begin
			step_buf[j].round_now = node_round;
			step_buf[j].leader_now = node_leader;
			expected_msgs.push_back(step_buf[j]);
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task automatic send_request(logic [1:0] c, logic [31:0] k, logic [2:0] from,
		logic [7:0] tr, logic v);
		int gap;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.round_k <= k;
		req.from_peer <= from;
		req.trust_mask <= tr;
		req.msg_valid <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_request(c, k, from, tr, v);
	endtask

	task automatic wait_drained();
		int guard;
		req.valid <= 1'b0;
		guard = 0;
		while (expected_msgs.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rble_pkg::CFG_PEER_COUNT) group_size = val;
		else self_index = val[2:0];
		@(posedge clk);
	endtask

	task automatic random_request();
		logic [1:0] c;
		logic [31:0] k;
		int sel;
		c = 2'($urandom_range(0, 3));
		sel = $urandom_range(0, 9);
		if (sel < 5) k = node_round;
		else if (sel < 7) k = node_round + $urandom_range(1, 9);
		else if (sel < 8) k = node_round - $urandom_range(1, 3);
		else k = $urandom;
		send_request(c, k, 3'($urandom_range(0, 7)), 8'($urandom),
			($urandom_range(0, 7) != 0));
	endtask

	task automatic test_directed();
		write_reg(rble_pkg::CFG_PEER_COUNT, 4'd4);
		write_reg(rble_pkg::CFG_MY_INDEX, 4'd0);
		send_request(rble_pkg::CMD_TICK, 32'd0, 3'd0, 8'h00, 1'b0);
		send_request(rble_pkg::CMD_ACK, 32'd0, 3'd2, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_ACK, 32'd0, 3'd7, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_TICK, 32'd0, 3'd0, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_TICK, 32'd0, 3'd0, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_START, 32'd9, 3'd1, 8'h00, 1'b0);
		send_request(rble_pkg::CMD_START, 32'd9, 3'd1, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_START, 32'd3, 3'd1, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_START, 32'd9, 3'd1, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_OK, 32'd5, 3'd6, 8'hFF, 1'b1);
		send_request(rble_pkg::CMD_OK, 32'd9, 3'd1, 8'hFE, 1'b1);
		send_request(rble_pkg::CMD_OK, 32'd10, 3'd1, 8'hFF, 1'b1);
		send_request(rble_pkg::CMD_OK, 32'd12, 3'd1, 8'hFF, 1'b1);
		send_request(rble_pkg::CMD_OK, 32'd12, 3'd1, 8'h00, 1'b0);
		send_request(rble_pkg::CMD_START, 32'hFFFF_FFFF, 3'd1, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_TICK, 32'hFFFF_FFFF, 3'd7, 8'hFF, 1'b1);
		send_request(rble_pkg::CMD_TICK, 32'd0, 3'd0, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_TICK, 32'd0, 3'd0, 8'h00, 1'b1);
		send_request(rble_pkg::CMD_OK, 32'hFFFF_FFFF, 3'd0, 8'h55, 1'b1);
		send_request(rble_pkg::CMD_ACK, 32'hFFFF_FFFF, 3'd3, 8'hAA, 1'b1);
		wait_drained();
	endtask

	task automatic test_group_sizes();
		logic [3:0] sizes [6] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'd5};
		logic [2:0] idx [6] = '{3'd0, 3'd7, 3'd7, 3'd2, 3'd6, 3'd1};
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		for (int p = 0; p < 6; p++) begin
			write_reg(rble_pkg::CFG_PEER_COUNT, sizes[p]);
			write_reg(rble_pkg::CFG_MY_INDEX, {1'b0, idx[p]});
			for (int i = 0; i < 30; i++) random_request();
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		write_reg(rble_pkg::CFG_PEER_COUNT, 4'd3);
		write_reg(rble_pkg::CFG_MY_INDEX, 4'd0);
		src_idle_on = 1'b0;
		hold_cycles = 300;
		for (int i = 0; i < 20; i++) random_request();
		wait_drained();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		for (int i = 0; i < 40; i++) random_request();
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
	end

	initial begin : sink_side
		int gap;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp.ready <= 1'b0;
			end else if (snk_idle_on && rsp.ready && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 16);
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rble_pkg::rble_res_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_msgs.size() == 0) begin
				report("unexpected result", 32'd0, 32'd0);
			end else begin
				w = expected_msgs.pop_front();
				if (rsp.has_msg !== w.has_msg)
					report("has_msg", 32'(rsp.has_msg), 32'(w.has_msg));
				if (rsp.msg_type !== w.msg_type)
					report("msg_type", 32'(rsp.msg_type), 32'(w.msg_type));
				if (rsp.msg_round !== w.msg_round)
					report("msg_round", rsp.msg_round, w.msg_round);
				if (rsp.broadcast !== w.broadcast)
					report("broadcast", 32'(rsp.broadcast), 32'(w.broadcast));
				if (rsp.dest_peer !== w.dest_peer)
					report("dest_peer", 32'(rsp.dest_peer), 32'(w.dest_peer));
				if (rsp.msg_trust !== w.msg_trust)
					report("msg_trust", 32'(rsp.msg_trust), 32'(w.msg_trust));
				if (rsp.msg_seq !== w.msg_seq) report("msg_seq", rsp.msg_seq, w.msg_seq);
				if (rsp.round_now !== w.round_now)
					report("round_now", rsp.round_now, w.round_now);
				if (rsp.leader_now !== w.leader_now)
					report("leader_now", 32'(rsp.leader_now), 32'(w.leader_now));
				if (rsp.last !== w.last) report("last", 32'(rsp.last), 32'(w.last));
			end
		end
	end

	initial begin
		errors = 0;
		hold_cycles = 0;
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		node_round = '0;
		node_leader = '0;
		for (int i = 0; i < 8; i++) lifetime[i] = 2'd3;
		ticks = '0;
		next_seq = '0;
		group_size = 4'd1;
		self_index = 3'd0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = 1'b0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.cmd = '0;
		req.round_k = '0;
		req.from_peer = '0;
		req.trust_mask = '0;
		req.msg_valid = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_group_sizes();
		test_backpressure();
		if (errors == 0 && expected_msgs.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

FILE: filelist.f
design/rble_pkg.sv
design/rble_if.sv
design/rble_front.sv
design/rble_mod.sv
design/rble_back.sv
design/round_based_leader_election.sv
sim/round_based_leader_election_tb.sv
